/* sv/clsc_pkg.sv */
// clsc_pkg: shared widths and types for the cpu load strip chart
// no dependencies; used by every module of the block

package clsc_pkg;

  localparam int TICK_W = 56;
  localparam int SUM_W  = 60;
  localparam int ROW_W  = 6;
  localparam int QUO_W  = 6;
  localparam int PAGE_W = 3;
  localparam int COL_W  = 7;
  localparam int BEAT_W = 64;
  localparam int NUM_TICKS = 8;

  typedef logic [ROW_W-1:0] row_t;

  // status of the row queue between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* sv/clsc_front.sv */
// clsc_front: accepts tick requests, forms idle and total sums, differences them
// and divides to a chart row; depends on clsc_pkg

module clsc_front #(
  parameter int ROWS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [clsc_pkg::TICK_W-1:0]   user_ticks_i,
  input  logic [clsc_pkg::TICK_W-1:0]   nice_ticks_i,
  input  logic [clsc_pkg::TICK_W-1:0]   system_ticks_i,
  input  logic [clsc_pkg::TICK_W-1:0]   idle_ticks_i,
  input  logic [clsc_pkg::TICK_W-1:0]   iowait_ticks_i,
  input  logic [clsc_pkg::TICK_W-1:0]   irq_ticks_i,
  input  logic [clsc_pkg::TICK_W-1:0]   softirq_ticks_i,
  input  logic [clsc_pkg::TICK_W-1:0]   steal_ticks_i,
  input  clsc_pkg::q_stat_t             q_stat_i,
  output logic                          push_o,
  output clsc_pkg::row_t                push_row_o
);

  localparam int SumW = clsc_pkg::SUM_W;
  localparam int QuoW = clsc_pkg::QUO_W;
  localparam int NumW = SumW + QuoW;
  localparam clsc_pkg::row_t Bottom = clsc_pkg::ROW_W'(ROWS - 1);

  typedef enum logic [6:0] {
    F_IDLE  = 7'b0000001,
    F_SUM   = 7'b0000010,
    F_DIFF  = 7'b0000100,
    F_CLASS = 7'b0001000,
    F_SCALE = 7'b0010000,
    F_DIV   = 7'b0100000,
    F_PUSH  = 7'b1000000
  } front_state_e;

  front_state_e state_q, state_d;

  logic [clsc_pkg::TICK_W-1:0] tick_q [clsc_pkg::NUM_TICKS];
  logic [2:0]        cnt_q;
  logic [SumW-1:0]   acc_q, acc_d;
  logic [SumW-1:0]   idle_q;
  logic [SumW-1:0]   prev_idle_q, prev_total_q;
  logic              primed_q;
  logic [SumW-1:0]   td_q, id_q, busy_q;
  logic              tot_le_q, idle_lt_q;
  logic [SumW-1:0]   rem_q;
  logic [QuoW-1:0]   low_q, quo_q;
  clsc_pkg::row_t    row_q;
  logic [NumW-1:0]   prod;
  logic [SumW:0]     trial;
  logic              ge;
  logic [QuoW-1:0]   quo_fin;

  assign acc_d   = acc_q + SumW'(tick_q[0]);
  assign prod    = NumW'(busy_q) * NumW'(Bottom);
  assign trial   = {rem_q, low_q[QuoW-1]};
  assign ge      = trial >= {1'b0, td_q};
  assign quo_fin = {quo_q[QuoW-2:0], ge};

  assign in_stall_o = (state_q != F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !q_stat_i.full;
  assign push_row_o = row_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (in_valid_i) state_d = F_SUM;
      F_SUM:   if (cnt_q == 3'd7) state_d = primed_q ? F_DIFF : F_IDLE;
      F_DIFF:  state_d = F_CLASS;
      F_CLASS: begin
        if (tot_le_q || idle_lt_q || (id_q > td_q) || (id_q == '0)) state_d = F_PUSH;
        else state_d = F_SCALE;
      end
      F_SCALE: state_d = F_DIV;
      F_DIV:   if (cnt_q == 3'(QuoW - 1)) state_d = F_PUSH;
      F_PUSH:  if (!q_stat_i.full) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= F_IDLE;
      primed_q     <= 1'b0;
      prev_idle_q  <= '0;
      prev_total_q <= '0;
      cnt_q        <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        F_IDLE: begin
          cnt_q <= '0;
        end
        F_SUM: begin
          if (cnt_q == 3'd7) begin
            cnt_q <= '0;
            if (!primed_q) begin
              primed_q     <= 1'b1;
              prev_idle_q  <= idle_q;
              prev_total_q <= acc_d;
            end
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        F_DIFF: begin
          prev_idle_q  <= idle_q;
          prev_total_q <= acc_q;
        end
        F_DIV: begin
          cnt_q <= cnt_q + 3'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          tick_q[0] <= idle_ticks_i;
          tick_q[1] <= iowait_ticks_i;
          tick_q[2] <= user_ticks_i;
          tick_q[3] <= nice_ticks_i;
          tick_q[4] <= system_ticks_i;
          tick_q[5] <= irq_ticks_i;
          tick_q[6] <= softirq_ticks_i;
          tick_q[7] <= steal_ticks_i;
          acc_q     <= '0;
        end
      end
      F_SUM: begin
        acc_q <= acc_d;
        for (int i = 0; i < clsc_pkg::NUM_TICKS - 1; i++) begin
          tick_q[i] <= tick_q[i+1];
        end
        if (cnt_q == 3'd1) idle_q <= acc_d;
      end
      F_DIFF: begin
        td_q      <= acc_q - prev_total_q;
        id_q      <= idle_q - prev_idle_q;
        tot_le_q  <= acc_q <= prev_total_q;
        idle_lt_q <= idle_q < prev_idle_q;
      end
      F_CLASS: begin
        busy_q <= td_q - id_q;
        if (tot_le_q) row_q <= Bottom;
        else if (idle_lt_q) row_q <= '0;
        else if (id_q > td_q) row_q <= Bottom;
        else row_q <= '0;
      end
      F_SCALE: begin
        rem_q <= prod[NumW-1:QuoW];
        low_q <= prod[QuoW-1:0];
        quo_q <= '0;
      end
      F_DIV: begin
        rem_q <= ge ? SumW'(trial - {1'b0, td_q}) : trial[SumW-1:0];
        low_q <= {low_q[QuoW-2:0], 1'b0};
        quo_q <= quo_fin;
        if (cnt_q == 3'(QuoW - 1)) begin
          row_q <= (quo_fin >= QuoW'(Bottom)) ? '0 : clsc_pkg::ROW_W'(Bottom - quo_fin);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/clsc_queue.sv */
// clsc_queue: two-entry queue of chart rows between front and back
// depends on clsc_pkg

module clsc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  clsc_pkg::row_t    push_row_i,
  input  logic              pop_i,
  output clsc_pkg::row_t    pop_row_o,
  output clsc_pkg::q_stat_t q_stat_o
);

  clsc_pkg::row_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign pop_row_o      = mem_q[rd_q];
  assign q_stat_o.full  = (cnt_q == 2'd2);
  assign q_stat_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_row_i;
  end

endmodule

/* sv/clsc_back.sv */
// clsc_back: scrolling row history and page-ordered frame emitter
// depends on clsc_pkg

module clsc_back #(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  clsc_pkg::q_stat_t             q_stat_i,
  input  clsc_pkg::row_t                pop_row_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [clsc_pkg::PAGE_W-1:0]   page_row_o,
  output logic [clsc_pkg::COL_W-1:0]    first_column_o,
  output logic [clsc_pkg::BEAT_W-1:0]   bytes_low_o,
  output logic [clsc_pkg::BEAT_W-1:0]   bytes_high_o,
  output logic                          frame_end_o
);

  localparam int Groups = COLUMNS / 16;
  localparam int Pages  = ROWS / 8;
  localparam int GrpW   = (Groups > 1) ? $clog2(Groups) : 1;
  localparam clsc_pkg::row_t Bottom = clsc_pkg::ROW_W'(ROWS - 1);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_EMIT = 2'b10
  } back_state_e;

  back_state_e state_q;
  clsc_pkg::row_t hist_q [COLUMNS];
  clsc_pkg::row_t hist_d [COLUMNS];
  logic [GrpW-1:0]             grp_q;
  logic [clsc_pkg::PAGE_W-1:0] page_q;
  logic                        out_valid_q;
  logic                        slot_free, beat, last;
  logic [clsc_pkg::BEAT_W-1:0] lo, hi;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign beat        = (state_q == B_EMIT) && slot_free;
  assign last        = (grp_q == GrpW'(Groups - 1)) &&
                       (page_q == clsc_pkg::PAGE_W'(Pages - 1));
  assign pop_o       = (state_q == B_IDLE) && !q_stat_i.empty;
  assign out_valid_o = out_valid_q;

  // at most one lit pixel per column on the current page, taken from the first sixteen history taps
  always_comb begin
    lo = '0;
    hi = '0;
    for (int c = 0; c < 8; c++) begin
      if (hist_q[c][5:3] == page_q) lo[c*8 + int'(hist_q[c][2:0])] = 1'b1;
      if (hist_q[c+8][5:3] == page_q) hi[c*8 + int'(hist_q[c+8][2:0])] = 1'b1;
    end
  end

  // push shifts in the newest row; each beat rotates one group to the front
  always_comb begin
    for (int i = 0; i < COLUMNS; i++) hist_d[i] = hist_q[i];
    if (pop_o) begin
      for (int i = 0; i < COLUMNS - 1; i++) hist_d[i] = hist_q[i+1];
      hist_d[COLUMNS-1] = pop_row_i;
    end else if (beat) begin
      for (int i = 0; i < COLUMNS; i++) hist_d[i] = hist_q[(i + 16) % COLUMNS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      grp_q       <= '0;
      page_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < COLUMNS; i++) hist_q[i] <= Bottom;
    end else begin
      for (int i = 0; i < COLUMNS; i++) hist_q[i] <= hist_d[i];
      if (beat) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            state_q <= B_EMIT;
            grp_q   <= '0;
            page_q  <= '0;
          end
        end
        B_EMIT: begin
          if (beat) begin
            if (grp_q == GrpW'(Groups - 1)) begin
              grp_q  <= '0;
              page_q <= page_q + clsc_pkg::PAGE_W'(1);
            end else begin
              grp_q <= grp_q + GrpW'(1);
            end
            if (last) state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat) begin
      page_row_o     <= page_q;
      first_column_o <= clsc_pkg::COL_W'({grp_q, 4'b0000});
      bytes_low_o    <= lo;
      bytes_high_o   <= hi;
      frame_end_o    <= last;
    end
  end

endmodule

/* sv/cpu_load_strip_chart_core.sv */
// cpu load strip chart, top level: front, row queue and frame emitter
// depends on clsc_pkg, clsc_front, clsc_queue, clsc_back
//
// - input channel: in_valid_i / in_stall_o with eight cumulative tick counters
//   per request. the front holds in_stall_o high while it works on a request.
// - output channel: out_valid_o / out_stall_i; every request except the first
//   after reset yields one frame of (ROWS/8)*(COLUMNS/16) results, 64 by
//   default, page by page and column group by column group; frame_end_o
//   marks the last result.
// - per request the front forms the sums serially on one adder, then does the
//   difference and scaling, the restoring divider and one push. within a
//   frame, results come one per cycle unless the receiver stalls.
// - the emitter sets the sustained rate; the two-entry row queue lets the
//   front take new requests while a frame is still going out.
// - when the receiver stalls, the current result holds and the emitter
//   waits; the queue fills and then the front stalls its input.
// - reset clears the stored sums and the primed flag and fills the history
//   with the bottom row; the first request afterwards only records sums.

module cpu_load_strip_chart_core #(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [clsc_pkg::TICK_W-1:0]   user_ticks_i,
  input  logic [clsc_pkg::TICK_W-1:0]   nice_ticks_i,
  input  logic [clsc_pkg::TICK_W-1:0]   system_ticks_i,
  input  logic [clsc_pkg::TICK_W-1:0]   idle_ticks_i,
  input  logic [clsc_pkg::TICK_W-1:0]   iowait_ticks_i,
  input  logic [clsc_pkg::TICK_W-1:0]   irq_ticks_i,
  input  logic [clsc_pkg::TICK_W-1:0]   softirq_ticks_i,
  input  logic [clsc_pkg::TICK_W-1:0]   steal_ticks_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [clsc_pkg::PAGE_W-1:0]   page_row_o,
  output logic [clsc_pkg::COL_W-1:0]    first_column_o,
  output logic [clsc_pkg::BEAT_W-1:0]   bytes_low_o,
  output logic [clsc_pkg::BEAT_W-1:0]   bytes_high_o,
  output logic                          frame_end_o
);

  clsc_pkg::q_stat_t q_stat;
  logic              push, pop;
  clsc_pkg::row_t    push_row, pop_row;

  clsc_front #(
    .ROWS (ROWS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .user_ticks_i    (user_ticks_i),
    .nice_ticks_i    (nice_ticks_i),
    .system_ticks_i  (system_ticks_i),
    .idle_ticks_i    (idle_ticks_i),
    .iowait_ticks_i  (iowait_ticks_i),
    .irq_ticks_i     (irq_ticks_i),
    .softirq_ticks_i (softirq_ticks_i),
    .steal_ticks_i   (steal_ticks_i),
    .q_stat_i        (q_stat),
    .push_o          (push),
    .push_row_o      (push_row)
  );

  clsc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_row_i (push_row),
    .pop_i      (pop),
    .pop_row_o  (pop_row),
    .q_stat_o   (q_stat)
  );

  clsc_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .pop_row_i      (pop_row),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .page_row_o     (page_row_o),
    .first_column_o (first_column_o),
    .bytes_low_o    (bytes_low_o),
    .bytes_high_o   (bytes_high_o),
    .frame_end_o    (frame_end_o)
  );

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("row pushed into a full queue");

  a_frame_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |->
      page_row_o == clsc_pkg::PAGE_W'(ROWS / 8 - 1) &&
      first_column_o == clsc_pkg::COL_W'(COLUMNS - 16))
    else $error("frame end not on the last page and group");

  a_frame_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !frame_end_o |=> out_valid_o)
    else $error("gap inside a frame");

  a_pixels_per_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({bytes_low_o, bytes_high_o}) <= 16)
    else $error("more than one lit pixel per column");
`endif

endmodule
